@@ rtl/core/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler core: operation
// codes, the classified command passed from front to back, and result bundle.
// ----------------------------------------------------------------------------
package pts_pkg;

   // default number of task slots
   localparam int TASK_SLOTS_DEFAULT = 8;

   // entries in the command queue between front and back (power of two)
   localparam int CMD_QUEUE_DEPTH = 2;

   // operation codes on the request channel
   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_CREATE = 3'd1,
      OP_KILL   = 3'd2,
      OP_DELAY  = 3'd3,
      OP_POLL   = 3'd4
   } op_type;

   // classified command kinds
   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_CREATE = 3'd1,
      CMD_KILL   = 3'd2,
      CMD_DELAY  = 3'd3,
      CMD_POLL   = 3'd4,
      CMD_REJECT = 3'd5
   } cmd_kind_type;

   // one classified transaction
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   task_priority;
      logic [2:0]   task_slot;
      logic [7:0]   delay_ticks;
   } cmd_type;

   // queue fill flags seen by front and back
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // result bundle from the back end
   typedef struct packed {
      logic        strobe;
      logic        status;
      logic [2:0]  selected_task;
      logic        new_cycle;
      logic [3:0]  running_count;
      logic [31:0] uptime_ticks;
   } rsp_type;

endpackage

@@ rtl/core/pts_front.sv @@
// ----------------------------------------------------------------------------
// pts_front
// Accepts request transactions, classifies them into commands and hands them
// to the command queue. Holds one command while the queue is full.
// ----------------------------------------------------------------------------
module pts_front #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_operation,
   input  logic [7:0]                req_task_priority,
   input  logic [2:0]                req_task_slot,
   input  logic [7:0]                req_delay_ticks,
   input  pts_pkg::queue_status_type q_status,
   output logic                      q_push,
   output pts_pkg::cmd_type          q_cmd
);
   import pts_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    accept;
   logic    kill_in_range;

   // handshake toward the request side and the queue
   assign busy   = valid_ff && q_status.full;
   assign accept = start && !busy;
   assign q_push = valid_ff && !q_status.full;
   assign q_cmd  = cmd_ff;

   assign kill_in_range = (32'(req_task_slot) < TASK_SLOTS);

   // classify the incoming transaction
   always_comb begin
      cmd_in               = cmd_ff;
      valid_in             = valid_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in             = 1'b1;
         cmd_in.task_priority = req_task_priority;
         cmd_in.task_slot     = req_task_slot;
         cmd_in.delay_ticks   = req_delay_ticks;
         unique case (req_operation)
            OP_TICK:   cmd_in.kind = CMD_TICK;
            OP_CREATE: cmd_in.kind = CMD_CREATE;
            OP_KILL:   cmd_in.kind = kill_in_range ? CMD_KILL : CMD_REJECT;
            OP_DELAY:  cmd_in.kind = CMD_DELAY;
            OP_POLL:   cmd_in.kind = CMD_POLL;
            default:   cmd_in.kind = CMD_REJECT;
         endcase
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // command payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

@@ rtl/core/pts_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// pts_cmd_queue
// Short first-in first-out queue of classified commands between the front
// and the back end.
// ----------------------------------------------------------------------------
module pts_cmd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pts_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output pts_pkg::cmd_type          head_cmd,
   output pts_pkg::queue_status_type status
);
   import pts_pkg::*;

   localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type          entry_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(CMD_QUEUE_DEPTH));
   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign do_pop       = pop && !status.empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/pts_back.sv @@
// ----------------------------------------------------------------------------
// pts_back
// Task table and executor. Pops commands, runs create, kill, delay and poll in
// one step, and runs a tick as a walk over the slots, one slot per cycle.
// ----------------------------------------------------------------------------
module pts_back #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pts_pkg::queue_status_type q_status,
   input  pts_pkg::cmd_type          q_head,
   output logic                      q_pop,
   output pts_pkg::rsp_type          rsp
);
   import pts_pkg::*;

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } back_state_type;

   back_state_type    state_ff;
   back_state_type    state_in;
   cmd_type           cmd_ff;
   cmd_type           cmd_in;

   logic [TASK_SLOTS-1:0] alive_ff;
   logic [TASK_SLOTS-1:0] alive_in;
   logic [TASK_SLOTS-1:0] fresh_ff;
   logic [TASK_SLOTS-1:0] fresh_in;
   logic [7:0]            prio_ff  [TASK_SLOTS];
   logic [7:0]            prio_in  [TASK_SLOTS];
   logic [7:0]            delay_ff [TASK_SLOTS];
   logic [7:0]            delay_in [TASK_SLOTS];
   logic [15:0]           run_ff   [TASK_SLOTS];
   logic [15:0]           run_in   [TASK_SLOTS];

   logic [SLOT_W-1:0] current_ff;
   logic [SLOT_W-1:0] current_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [31:0]       uptime_ff;
   logic [31:0]       uptime_in;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] idx_in;
   logic [SLOT_W-1:0] best_ff;
   logic [SLOT_W-1:0] best_in;
   logic [7:0]        best_prio_ff;
   logic [7:0]        best_prio_in;
   logic              resp_ff;
   logic              resp_in;
   logic              status_ff;
   logic              status_in;
   logic              newcycle_ff;
   logic              newcycle_in;

   logic              free_found;
   logic [SLOT_W-1:0] free_slot;
   logic [SLOT_W-1:0] kill_slot;
   logic [7:0]        scan_delay;
   logic [7:0]        scan_prio;
   logic              scan_alive;

   // lowest free slot for create
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!alive_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   assign kill_slot  = SLOT_W'(cmd_ff.task_slot);
   assign scan_delay = delay_ff[idx_ff];
   assign scan_prio  = prio_ff[idx_ff];
   assign scan_alive = alive_ff[idx_ff];

   // sequencer and table updates
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      alive_in     = alive_ff;
      fresh_in     = fresh_ff;
      prio_in      = prio_ff;
      delay_in     = delay_ff;
      run_in       = run_ff;
      current_in   = current_ff;
      count_in     = count_ff;
      uptime_in    = uptime_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      resp_in      = 1'b0;
      status_in    = status_ff;
      newcycle_in  = newcycle_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               idx_in   = '0;
               state_in = (q_head.kind == CMD_TICK) ? ST_SCAN : ST_EXEC;
            end
         end

         ST_EXEC: begin
            resp_in     = 1'b1;
            status_in   = 1'b0;
            newcycle_in = 1'b0;
            state_in    = ST_IDLE;
            case (cmd_ff.kind)
               CMD_CREATE: begin
                  if (free_found) begin
                     prio_in[free_slot]  = cmd_ff.task_priority;
                     delay_in[free_slot] = '0;
                     run_in[free_slot]   = '0;
                     fresh_in[free_slot] = 1'b0;
                     alive_in[free_slot] = 1'b1;
                     count_in            = count_ff + CNT_W'(1);
                  end else begin
                     status_in = 1'b1;
                  end
               end
               CMD_KILL: begin
                  if (alive_ff[kill_slot]) begin
                     alive_in[kill_slot] = 1'b0;
                     count_in            = count_ff - CNT_W'(1);
                  end else begin
                     status_in = 1'b1;
                  end
               end
               CMD_DELAY: begin
                  delay_in[current_ff] = cmd_ff.delay_ticks;
               end
               CMD_POLL: begin
                  newcycle_in          = fresh_ff[current_ff];
                  fresh_in[current_ff] = 1'b0;
               end
               default: begin
                  status_in = 1'b1;
               end
            endcase
         end

         // one slot per cycle: candidate compare and delay countdown
         ST_SCAN: begin
            if (idx_ff == '0) begin
               best_in      = '0;
               best_prio_in = scan_prio;
               if (scan_delay != 8'd0) begin
                  delay_in[idx_ff] = scan_delay - 8'd1;
               end
            end else begin
               if (scan_alive && (scan_delay == 8'd0) && (scan_prio < best_prio_ff)) begin
                  best_in      = idx_ff;
                  best_prio_in = scan_prio;
               end
               if (scan_alive && (scan_delay != 8'd0)) begin
                  delay_in[idx_ff] = scan_delay - 8'd1;
               end
            end
            if (idx_ff == SLOT_W'(TASK_SLOTS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         ST_FINISH: begin
            current_in        = best_ff;
            run_in[best_ff]   = run_ff[best_ff] + 16'd1;
            fresh_in[best_ff] = 1'b1;
            uptime_in         = uptime_ff + 32'd1;
            resp_in           = 1'b1;
            status_in         = 1'b0;
            newcycle_in       = 1'b0;
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and reset-cleared table entries
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         alive_ff   <= '0;
         fresh_ff   <= '0;
         current_ff <= '0;
         count_ff   <= '0;
         uptime_ff  <= '0;
         resp_ff    <= 1'b0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            delay_ff[i] <= '0;
            run_ff[i]   <= '0;
         end
      end else begin
         state_ff   <= state_in;
         alive_ff   <= alive_in;
         fresh_ff   <= fresh_in;
         current_ff <= current_in;
         count_ff   <= count_in;
         uptime_ff  <= uptime_in;
         resp_ff    <= resp_in;
         delay_ff   <= delay_in;
         run_ff     <= run_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      prio_ff      <= prio_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      status_ff    <= status_in;
      newcycle_ff  <= newcycle_in;
   end

   // result bundle straight from registers
   assign rsp.strobe        = resp_ff;
   assign rsp.status        = status_ff;
   assign rsp.selected_task = 3'(current_ff);
   assign rsp.new_cycle     = newcycle_ff;
   assign rsp.running_count = 4'(count_ff);
   assign rsp.uptime_ticks  = uptime_ff;

endmodule

@@ rtl/core/priority_task_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// priority_task_scheduler_core
// Fixed-priority preemptive task table: create, kill, delay, poll and tick.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy rises only
//   when the front register holds a command and the command queue is full.
//   Result channel: one result per transaction, in request order, shown on
//   rsp_* for exactly one cycle while rsp_strobe is high. The receiver
//   cannot stall, so rsp_strobe is never held.
//   Path: a request passes the front register and the command queue; the back
//   end pops it into its command register, runs it and registers the result.
//   A tick first walks the task table, visiting one slot per cycle, and a
//   command waits in the queue while the back end is busy with an earlier one.
//   Front and queue keep taking requests meanwhile, up to the queue depth plus
//   one.
//   Reset: clears all tasks, delays, flags, the selected task and uptime;
//   queued transactions are dropped. No clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_task_scheduler_core #(
   parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_task_priority,
   input  logic [2:0]  req_task_slot,
   input  logic [7:0]  req_delay_ticks,
   output logic        rsp_strobe,
   output logic        rsp_status,
   output logic [2:0]  rsp_selected_task,
   output logic        rsp_new_cycle,
   output logic [3:0]  rsp_running_count,
   output logic [31:0] rsp_uptime_ticks
);
   import pts_pkg::*;

   queue_status_type q_stat;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             q_push;
   logic             q_pop;
   rsp_type          rsp;

   // front: accept and classify
   pts_front #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_task_priority (req_task_priority),
      .req_task_slot     (req_task_slot),
      .req_delay_ticks   (req_delay_ticks),
      .q_status          (q_stat),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   // queue between front and back
   pts_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_stat)
   );

   // back: task table and executor
   pts_back #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_stat),
      .q_head   (head_cmd),
      .q_pop    (q_pop),
      .rsp      (rsp)
   );

   // result ports
   assign rsp_strobe        = rsp.strobe;
   assign rsp_status        = rsp.status;
   assign rsp_selected_task = rsp.selected_task;
   assign rsp_new_cycle     = rsp.new_cycle;
   assign rsp_running_count = rsp.running_count;
   assign rsp_uptime_ticks  = rsp.uptime_ticks;

`ifndef SYNTH
   // back end passes through idle between results, so the strobe never stays high
   a_rsp_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two consecutive cycles");

   // front never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("push into full command queue");

   // live task count never exceeds the slot count
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((TASK_SLOTS > 15) || (32'(rsp_running_count) <= TASK_SLOTS)))
      else $error("running count above slot count");

   // no result right after reset
   a_reset_quiet : assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");
`endif

endmodule

@@ dv/priority_task_scheduler_core_tb.sv @@
// ----------------------------------------------------------------------------
// priority_task_scheduler_core_tb
// Self-checking bench for the task scheduler core. A behavioral copy of the
// task table predicts every result at the edge a request is taken; a checker
// compares each strobed result, field by field, with the oldest prediction.
// Directed tests cover the empty table, refused requests, a full table,
// priority ties and delays. A long random run of create/kill/delay/poll/tick
// traffic follows, with bursty request timing and full drain pauses.
// ----------------------------------------------------------------------------
module priority_task_scheduler_core_tb;
   import pts_pkg::*;

   localparam int SLOTS         = TASK_SLOTS_DEFAULT;
   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = SLOTS + 8;
   localparam int RANDOM_ITEMS  = 925;
   localparam int MAX_REPORTS   = 10;

   // operation codes the block refuses
   localparam logic [2:0] OP_BAD_LOW  = 3'd5;
   localparam logic [2:0] OP_BAD_MID  = 3'd6;
   localparam logic [2:0] OP_BAD_HIGH = 3'd7;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef struct packed {
      logic        status;
      logic [2:0]  selected;
      logic        new_cycle;
      logic [3:0]  running;
      logic [31:0] uptime;
   } sched_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_operation;
   logic [7:0]  req_task_priority;
   logic [2:0]  req_task_slot;
   logic [7:0]  req_delay_ticks;
   logic        rsp_strobe;
   logic        rsp_status;
   logic [2:0]  rsp_selected_task;
   logic        rsp_new_cycle;
   logic [3:0]  rsp_running_count;
   logic [31:0] rsp_uptime_ticks;

   // predicted task table
   logic [SLOTS-1:0] sched_alive;
   logic [7:0]       sched_priority [SLOTS];
   logic [7:0]       sched_delay [SLOTS];
   logic [15:0]      sched_run_ticks [SLOTS];
   logic             sched_fresh [SLOTS];
   logic [2:0]       sched_current;
   logic [3:0]       sched_count;
   logic [31:0]      sched_uptime;

   sched_result_type pending_results [$];
   int               op_counts [8];
   int               refused_count;
   int               peak_fill;
   int               drain_pauses;
   int               checked_count;
   int               failure_count;
   int               idle_cycles;

   priority_task_scheduler_core #(
      .TASK_SLOTS(SLOTS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_task_priority (req_task_priority),
      .req_task_slot     (req_task_slot),
      .req_delay_ticks   (req_delay_ticks),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_selected_task (rsp_selected_task),
      .rsp_new_cycle     (rsp_new_cycle),
      .rsp_running_count (rsp_running_count),
      .rsp_uptime_ticks  (rsp_uptime_ticks)
   );

   // free-running clock
   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // table state right after reset
   function automatic void clear_schedule();
      sched_alive   = '0;
      sched_current = '0;
      sched_count   = '0;
      sched_uptime  = '0;
      for (int s = 0; s < SLOTS; s++) begin
         sched_priority[s]  = '0;
         sched_delay[s]     = '0;
         sched_run_ticks[s] = '0;
         sched_fresh[s]     = 1'b0;
      end
   endfunction

   // apply one transaction to the predicted table and return its result;
   // slot 0 is always the first slot created, so its priority is written
   // before any other task can be compared against it
   function automatic sched_result_type predict_schedule(logic [2:0] op, logic [7:0] prio,
                                                         logic [2:0] slot, logic [7:0] dly);
      sched_result_type want;
      int               best;
      int               free_slot;
      want        = '0;
      want.status = STATUS_OK;
      case (op)
         OP_TICK: begin
            best = 0;
            for (int s = 1; s < SLOTS; s++) begin
               if (sched_alive[s] && sched_delay[s] == 8'd0 &&
                   sched_priority[s] < sched_priority[best])
                  best = s;
            end
            // slot 0 counts down even when it is not alive
            for (int s = 0; s < SLOTS; s++) begin
               if ((s == 0 || sched_alive[s]) && sched_delay[s] != 8'd0)
                  sched_delay[s] = sched_delay[s] - 8'd1;
            end
            sched_current          = 3'(best);
            sched_run_ticks[best]  = sched_run_ticks[best] + 16'd1;
            sched_fresh[best]      = 1'b1;
            sched_uptime           = sched_uptime + 32'd1;
         end
         OP_CREATE: begin
            free_slot = -1;
            for (int s = SLOTS - 1; s >= 0; s--) begin
               if (!sched_alive[s])
                  free_slot = s;
            end
            if (free_slot < 0) begin
               want.status = STATUS_REFUSED;
            end else begin
               sched_priority[free_slot]  = prio;
               sched_delay[free_slot]     = '0;
               sched_run_ticks[free_slot] = '0;
               sched_fresh[free_slot]     = 1'b0;
               sched_alive[free_slot]     = 1'b1;
               sched_count                = sched_count + 4'd1;
            end
         end
         OP_KILL: begin
            if (int'(slot) >= SLOTS || !sched_alive[slot]) begin
               want.status = STATUS_REFUSED;
            end else begin
               sched_alive[slot] = 1'b0;
               sched_count       = sched_count - 4'd1;
            end
         end
         OP_DELAY: begin
            sched_delay[sched_current] = dly;
         end
         OP_POLL: begin
            want.new_cycle             = sched_fresh[sched_current];
            sched_fresh[sched_current] = 1'b0;
         end
         default: begin
            want.status = STATUS_REFUSED;
         end
      endcase
      op_counts[op]++;
      if (want.status == STATUS_REFUSED)
         refused_count++;
      if (int'(sched_count) > peak_fill)
         peak_fill = int'(sched_count);
      want.selected = sched_current;
      want.running  = sched_count;
      want.uptime   = sched_uptime;
      return want;
   endfunction

   // drive one transaction and hold it until the block takes it
   task automatic send_item(logic [2:0] op, logic [7:0] prio, logic [2:0] slot,
                            logic [7:0] dly);
      start             <= 1'b1;
      req_operation     <= op;
      req_task_priority <= prio;
      req_task_slot     <= slot;
      req_delay_ticks   <= dly;
      do
         @(posedge clock);
      while (busy);
      pending_results.push_back(predict_schedule(op, prio, slot, dly));
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every outstanding result has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      drain_pauses++;
   endtask

   task automatic note_failure(string msg);
      failure_count++;
      if (failure_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got)
         note_failure($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // compare each strobed result with the oldest prediction
   always @(posedge clock) begin : result_check
      sched_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            note_failure("result strobed with no transaction outstanding");
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("selected_task", 32'(want.selected), 32'(rsp_selected_task));
            check_field("new_cycle", 32'(want.new_cycle), 32'(rsp_new_cycle));
            check_field("running_count", 32'(want.running), 32'(rsp_running_count));
            check_field("uptime_ticks", want.uptime, rsp_uptime_ticks);
         end
      end
   end

   // watchdog on cycles with no transaction moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, pending_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // empty table: poll, delay and tick act on slot 0 while nothing is alive
   task automatic test_idle_table();
      send_item(OP_POLL, 8'h00, 3'd0, 8'h00);
      send_item(OP_DELAY, 8'hff, 3'd7, 8'hff);
      send_item(OP_TICK, 8'h00, 3'd0, 8'h00);
      send_item(OP_POLL, 8'hff, 3'd7, 8'hff);
      send_item(OP_POLL, 8'h00, 3'd0, 8'h00);
   endtask

   // kills of dead slots and unused operation codes
   task automatic test_refused_requests();
      send_item(OP_KILL, 8'h00, 3'd0, 8'h00);
      send_item(OP_KILL, 8'hff, 3'd7, 8'hff);
      send_item(OP_BAD_LOW, 8'h00, 3'd0, 8'h00);
      send_item(OP_BAD_MID, 8'h5a, 3'd5, 8'ha5);
      send_item(OP_BAD_HIGH, 8'hff, 3'd7, 8'hff);
   endtask

   // fill every slot, then one create too many
   task automatic test_full_table();
      logic [7:0] prios [SLOTS];
      prios = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd1, 8'd254, 8'd127, 8'd200};
      for (int s = 0; s < SLOTS; s++)
         send_item(OP_CREATE, prios[s], 3'(s), 8'h00);
      send_item(OP_CREATE, 8'd0, 3'd0, 8'h00);
   endtask

   // ties keep the lower slot, delayed tasks are skipped, kill of current
   task automatic test_priority_pick();
      send_item(OP_TICK, 8'h00, 3'd0, 8'h00);
      send_item(OP_DELAY, 8'h00, 3'd0, 8'd3);
      send_item(OP_TICK, 8'h00, 3'd0, 8'h00);
      send_item(OP_KILL, 8'h00, 3'd3, 8'h00);
      send_item(OP_TICK, 8'h00, 3'd0, 8'h00);
      send_item(OP_POLL, 8'h00, 3'd0, 8'h00);
   endtask

   // random traffic: mostly well-formed, bursty timing, two full drains
   task automatic test_random_traffic();
      int         burst_left;
      int         roll;
      logic [2:0] op;
      logic [7:0] prio;
      logic [2:0] slot;
      logic [7:0] dly;
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
            wait_for_drain();
         // sender gaps between bursts, some bursts long enough to saturate
         if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 2)
               pause_sender($urandom_range(15, 40));
            else
               pause_sender($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
         end
         burst_left--;

         prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 7));
         slot = 3'($urandom_range(0, 7));
         dly  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 4));
         roll = $urandom_range(0, 99);
         if (roll < 3)
            op = 3'($urandom_range(int'(OP_BAD_LOW), int'(OP_BAD_HIGH)));
         else if (roll < 40)
            op = OP_TICK;
         else if (roll < 58)
            op = OP_CREATE;
         else if (roll < 76)
            op = OP_KILL;
         else if (roll < 89)
            op = OP_DELAY;
         else
            op = OP_POLL;
         // most kills target a live slot
         if (op == OP_KILL && sched_alive != '0 && $urandom_range(0, 9) < 8) begin
            while (!sched_alive[slot])
               slot = 3'($urandom_range(0, 7));
         end
         send_item(op, prio, slot, dly);
      end
   endtask

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_operation     <= OP_TICK;
      req_task_priority <= '0;
      req_task_slot     <= '0;
      req_delay_ticks   <= '0;
      idle_cycles       = 0;
      refused_count     = 0;
      peak_fill         = 0;
      drain_pauses      = 0;
      checked_count     = 0;
      failure_count     = 0;
      for (int i = 0; i < 8; i++)
         op_counts[i] = 0;
      clear_schedule();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_table();
      test_refused_requests();
      test_full_table();
      test_priority_pick();
      test_random_traffic();

      // let the pipeline empty out
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered: %0d tick, %0d create, %0d kill, %0d delay, %0d poll, %0d bad code",
               op_counts[OP_TICK], op_counts[OP_CREATE], op_counts[OP_KILL],
               op_counts[OP_DELAY], op_counts[OP_POLL],
               op_counts[OP_BAD_LOW] + op_counts[OP_BAD_MID] + op_counts[OP_BAD_HIGH]);
      $display("%0d results checked, %0d refused, peak fill %0d, %0d drains, %0d failures",
               checked_count, refused_count, peak_fill, drain_pauses, failure_count);
      if (failure_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/pts_pkg.sv
rtl/core/pts_front.sv
rtl/core/pts_cmd_queue.sv
rtl/core/pts_back.sv
rtl/core/priority_task_scheduler_core.sv
dv/priority_task_scheduler_core_tb.sv
